FILE: rtl/rfs_pkg.sv
// Shared types, codes and constants for the rotating first-free server assignment block
`timescale 1ns / 1ps
`default_nettype none

package rfs_pkg;

    // field widths fixed by the item format
    localparam int TIME_W = 30;
    localparam int FT_W   = 31;
    localparam int CNT_W  = 32;
    localparam int IDX_W  = 6;
    localparam int CFG_W  = 7;

    localparam logic [CFG_W-1:0] CFG_RESET = 7'd16;
    localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};
    localparam logic [FT_W-1:0]  FT_RESET  = 31'd1;

    // operation codes
    localparam logic OP_ASSIGN = 1'b0;
    localparam logic OP_REPORT = 1'b1;

    typedef struct packed {
        logic              op;
        logic [TIME_W-1:0] arrival_time;
        logic [TIME_W-1:0] service_time;
    } req_t;

    typedef struct packed {
        logic [IDX_W-1:0] server_index;
        logic [CNT_W-1:0] request_count;
        logic             dropped;
        logic             last;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NORM,
        ST_ASSIGN,
        ST_MAX,
        ST_LIST
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic norm_step;
        logic scan_init;
        logic scan_run;
        logic max_update;
        logic commit;
        logic drop;
        logic list_emit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_report;
        logic start_ok;
        logic chk_valid;
        logic chk_last;
        logic hit;
        logic eq;
        logic is_last_idx;
    } sts_t;

endpackage

`default_nettype wire

FILE: rtl/rotating_first_free_server_assign.sv
// Top level of the rotating first-free server assignment block
//
//  channel   signals                     handshake
//  -------   -------------------------   ----------------------------------
//  request   start, busy, req            transfer when start and not busy
//  result    result_strobe, result       one cycle per transfer, no stall
//  config    cfg_we, cfg_wdata           write when cfg_we, no wait
//
// An assign checks m servers (1 to k) from the start pointer; when k has shrunk
// to or below the start pointer, k is first subtracted from it until it is below k.
// A report makes two passes: one finds the top count, a second lists matching
// servers, one per cycle. Both passes read the server RAM once per cycle
// through its registered read port. Reset is immediate: per-entry valid
// flip-flops stand in for the reset contents, so no clearing pass is needed.
// The receiver cannot stall; each result is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module rotating_first_free_server_assign #(
    parameter int NUM_SERVERS = 16
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire rfs_pkg::req_t             req,
    output logic                           result_strobe,
    output rfs_pkg::rsp_t                  result,
    input  wire logic                      cfg_we,
    input  wire logic [rfs_pkg::CFG_W-1:0] cfg_wdata
);

    import rfs_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // sequencing
    rfs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    // storage and arithmetic
    rfs_datapath #(
        .NUM_SERVERS (NUM_SERVERS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .req           (req),
        .cmd           (cmd),
        .sts           (sts),
        .result_strobe (result_strobe),
        .result        (result)
    );

endmodule

`default_nettype wire

FILE: rtl/rfs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data
`timescale 1ns / 1ps
`default_nettype none

module rfs_ram #(
    parameter int WIDTH = 63,
    parameter int DEPTH = 16
) (
    input  wire logic                             clk,
    input  wire logic                             wr_en,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                 wr_data,
    input  wire logic                             rd_en,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/rfs_ctrl.sv
// Controller state machine sequencing the server scans
`timescale 1ns / 1ps
`default_nettype none

module rfs_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire rfs_pkg::sts_t sts,
    output rfs_pkg::cmd_t      cmd
);

    import rfs_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_NORM;
                end
            end
            ST_NORM:
            begin
                if (sts.is_report)
                begin
                    state_next = ST_MAX;
                end
                else if (sts.start_ok)
                begin
                    state_next = ST_ASSIGN;
                end
            end
            ST_ASSIGN:
            begin
                if (sts.chk_valid && (sts.hit || sts.chk_last))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MAX:
            begin
                if (sts.chk_valid && sts.chk_last)
                begin
                    state_next = ST_LIST;
                end
            end
            ST_LIST:
            begin
                if (sts.chk_valid && sts.eq && sts.is_last_idx)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_NORM:
            begin
                if (sts.is_report || sts.start_ok)
                begin
                    cmd.scan_init = 1'b1;
                end
                else
                begin
                    cmd.norm_step = 1'b1;
                end
            end
            ST_ASSIGN:
            begin
                cmd.scan_run = 1'b1;
                if (sts.chk_valid && sts.hit)
                begin
                    cmd.commit = 1'b1;
                end
                else if (sts.chk_valid && sts.chk_last)
                begin
                    cmd.drop = 1'b1;
                end
            end
            ST_MAX:
            begin
                cmd.max_update = sts.chk_valid;
                if (sts.chk_valid && sts.chk_last)
                begin
                    cmd.scan_init = 1'b1;
                end
                else
                begin
                    cmd.scan_run = 1'b1;
                end
            end
            ST_LIST:
            begin
                cmd.scan_run  = 1'b1;
                cmd.list_emit = sts.chk_valid && sts.eq;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/rfs_datapath.sv
// Datapath: server state memory, scan pipeline, pointer and result registers
`timescale 1ns / 1ps
`default_nettype none

module rfs_datapath #(
    parameter int NUM_SERVERS = 16
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [rfs_pkg::CFG_W-1:0]  cfg_wdata,
    input  wire rfs_pkg::req_t              req,
    input  wire rfs_pkg::cmd_t              cmd,
    output rfs_pkg::sts_t                   sts,
    output logic                            result_strobe,
    output rfs_pkg::rsp_t                   result
);

    import rfs_pkg::*;

    localparam int AW = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
    localparam int DW = FT_W + CNT_W;
    localparam logic [CFG_W-1:0] K_MAX = CFG_W'(NUM_SERVERS);

    logic [CFG_W-1:0]       cfg_reg;
    logic [CFG_W-1:0]       k_eff;
    logic [CFG_W-1:0]       k_m1;
    req_t                   item_reg;
    logic [IDX_W-1:0]       ptr_reg;
    logic [IDX_W-1:0]       start_reg;
    logic [CFG_W-1:0]       start_inc;
    logic [AW-1:0]          rd_addr_reg;
    logic [CFG_W-1:0]       rd_cnt_reg;
    logic                   chk_valid_reg;
    logic                   chk_last_reg;
    logic [AW-1:0]          chk_addr_reg;
    logic [NUM_SERVERS-1:0] vld_reg;
    logic                   vld_q_reg;
    logic [CNT_W-1:0]       best_reg;
    logic [AW-1:0]          last_idx_reg;
    logic                   res_strobe_reg;
    rsp_t                   res_reg;
    logic                   issue_en;
    logic                   rd_en;
    logic [DW-1:0]          rd_data;
    logic [FT_W-1:0]        ft_q;
    logic [CNT_W-1:0]       cnt_q;
    logic [CNT_W-1:0]       new_cnt;
    logic [FT_W-1:0]        new_ft;
    logic                   hit;
    logic                   eq;
    logic                   gt;

    // server count register and its clamped value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            cfg_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        if (cfg_reg == '0)
        begin
            k_eff = CFG_W'(1);
        end
        else if (cfg_reg > K_MAX)
        begin
            k_eff = K_MAX;
        end
        else
        begin
            k_eff = cfg_reg;
        end
    end

    assign k_m1 = k_eff - CFG_W'(1);

    // captured item
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= req;
        end
    end

    // rotating start pointer, advanced once per assign request
    assign start_inc = {1'b0, start_reg} + CFG_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
        end
        else if (cmd.commit || cmd.drop)
        begin
            ptr_reg <= (start_inc == k_eff) ? '0 : IDX_W'(start_inc);
        end
    end

    // search start: pointer reduced below k by repeated subtraction
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            start_reg <= ptr_reg;
        end
        else if (cmd.norm_step)
        begin
            start_reg <= IDX_W'({1'b0, start_reg} - k_eff);
        end
    end

    // read issue side of the scan pipeline
    assign issue_en = rd_cnt_reg < k_eff;
    assign rd_en    = cmd.scan_run && issue_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chk_valid_reg <= 1'b0;
        end
        else if (cmd.scan_init)
        begin
            chk_valid_reg <= 1'b0;
        end
        else if (cmd.scan_run)
        begin
            chk_valid_reg <= issue_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_init)
        begin
            rd_addr_reg <= item_reg.op == OP_REPORT ? '0 : start_reg[AW-1:0];
            rd_cnt_reg  <= '0;
        end
        else if (rd_en)
        begin
            rd_addr_reg  <= (CFG_W'(rd_addr_reg) == k_m1) ? '0 : rd_addr_reg + AW'(1);
            rd_cnt_reg   <= rd_cnt_reg + CFG_W'(1);
            chk_addr_reg <= rd_addr_reg;
            chk_last_reg <= rd_cnt_reg == k_m1;
            vld_q_reg    <= vld_reg[rd_addr_reg];
        end
    end

    // server state: free time in the upper bits, request count in the lower
    rfs_ram #(
        .WIDTH (DW),
        .DEPTH (NUM_SERVERS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (cmd.commit),
        .wr_addr (chk_addr_reg),
        .wr_data ({new_ft, new_cnt}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr_reg),
        .rd_data (rd_data)
    );

    // entries never written read as their reset values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (cmd.commit)
        begin
            vld_reg[chk_addr_reg] <= 1'b1;
        end
    end

    assign ft_q  = vld_q_reg ? rd_data[DW-1:CNT_W] : FT_RESET;
    assign cnt_q = vld_q_reg ? rd_data[CNT_W-1:0] : '0;

    // check side compares
    assign hit     = ft_q <= {1'b0, item_reg.arrival_time};
    assign eq      = cnt_q == best_reg;
    assign gt      = cnt_q > best_reg;
    assign new_cnt = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + CNT_W'(1);
    assign new_ft  = {1'b0, item_reg.arrival_time} + {1'b0, item_reg.service_time};

    // running maximum and the last index that holds it
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            best_reg     <= '0;
            last_idx_reg <= '0;
        end
        else if (cmd.max_update)
        begin
            if (gt)
            begin
                best_reg     <= cnt_q;
                last_idx_reg <= chk_addr_reg;
            end
            else if (eq)
            begin
                last_idx_reg <= chk_addr_reg;
            end
        end
    end

    // result register, one cycle per transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_strobe_reg <= 1'b0;
        end
        else
        begin
            res_strobe_reg <= cmd.commit || cmd.drop || cmd.list_emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            res_reg.server_index  <= IDX_W'(chk_addr_reg);
            res_reg.request_count <= new_cnt;
            res_reg.dropped       <= 1'b0;
            res_reg.last          <= 1'b1;
        end
        else if (cmd.drop)
        begin
            res_reg.server_index  <= '0;
            res_reg.request_count <= '0;
            res_reg.dropped       <= 1'b1;
            res_reg.last          <= 1'b1;
        end
        else if (cmd.list_emit)
        begin
            res_reg.server_index  <= IDX_W'(chk_addr_reg);
            res_reg.request_count <= best_reg;
            res_reg.dropped       <= 1'b0;
            res_reg.last          <= chk_addr_reg == last_idx_reg;
        end
    end

    assign result_strobe = res_strobe_reg;
    assign result        = res_reg;

    // status to the controller
    assign sts.is_report   = item_reg.op == OP_REPORT;
    assign sts.start_ok    = {1'b0, start_reg} < k_eff;
    assign sts.chk_valid   = chk_valid_reg;
    assign sts.chk_last    = chk_last_reg;
    assign sts.hit         = hit;
    assign sts.eq          = eq;
    assign sts.is_last_idx = chk_addr_reg == last_idx_reg;

endmodule

`default_nettype wire
